// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the setpoint limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that, when seen, must come with a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/elsl_pkg.sv -----
// Constants, types and divider interface structs for the setpoint limiter.
`timescale 1ns / 1ps

package elsl_pkg;

    localparam int ADC_BITS = 12;
    localparam int CODE_W = 12;
    localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((1 << ADC_BITS) - 1);

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    localparam int CMD_MODE_BIT = 15;
    localparam int SET_W = 15;

    localparam int MV_PER_STEP = 50;
    localparam int T_GAIN = 754;
    localparam int T_DIV = 9500;
    localparam int T_OFFSET = 50;
    localparam int P_BASE = 280000;
    localparam int P_SLOPE = 2200;
    localparam int P_REF_TEMP = 25;
    localparam int P_CAP = 240000;
    localparam int P_SCALE = 10;
    localparam int I_CAP = 20000;
    localparam int V_MIN_MV = 2000;
    localparam int T_MAX_C = 125;
    localparam int MILLI = 1000;

    localparam int VMV_W = 18;
    localparam int TPROD_W = 22;
    localparam int TEMP_W = 10;
    localparam int PWR_W = 18;
    localparam int PREQ_W = 19;
    localparam int MP_W = 21;
    localparam int PROD_W = 28;
    localparam int SETP_W = 17;
    localparam int LIM_W = 15;

    // Divider geometry: remainder width, quotient width and step count width.
    localparam int REM_W = 18;
    localparam int QUOT_W = 17;
    localparam int STEP_W = 5;
    localparam int TEMP_QW = 9;

    localparam logic signed [MP_W-1:0] P_INTERCEPT_S = MP_W'(P_BASE + P_SLOPE * P_REF_TEMP);
    localparam logic signed [MP_W-1:0] P_SLOPE_S = MP_W'(P_SLOPE);
    localparam logic signed [MP_W-1:0] P_CAP_S = MP_W'(P_CAP);
    localparam logic signed [TEMP_W-1:0] T_MAX_S = TEMP_W'(T_MAX_C);

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] low;
        logic [REM_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/elsl_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module elsl_div import elsl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [REM_W-1:0]  r_den;

    logic [REM_W:0]    n_trial;
    logic [REM_W:0]    n_diff;
    logic              n_bit;
    logic [REM_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_low[QUOT_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_bit   = n_trial >= {1'b0, r_den};
        n_rem   = n_bit ? n_diff[REM_W-1:0] : n_trial[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_low  <= i_req.low;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], n_bit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- rtl/electronic_load_setpoint_limiter.sv -----
// Top level of the setpoint limiter: sequencer, power derating and output register.
//
//  channel  direction  handshake         payload
//  input    in         i_valid/o_stall   operation, command word, voltage and temperature codes
//  output   out        o_valid/i_stall   setpoint, limit, millivolts, degrees, two flags
//
// A command word is taken without leaving the idle state and gives no word on the output.
// A measurement below 2 V skips the current divisions, current mode runs one and power mode two;
// the serial divider sets its length, with 9 steps for degrees and 17 for each current division.
// Reset clears the mode and both stored setpoints and empties the output register.
// A measurement may be taken while the previous result waits; it finishes when that is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module electronic_load_setpoint_limiter import elsl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  logic [15:0]              i_command_word,
    input  logic [CODE_W-1:0]        i_voltage_code,
    input  logic [CODE_W-1:0]        i_temperature_code,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [SETP_W-1:0]        o_current_setpoint_ma,
    output logic [LIM_W-1:0]         o_current_limit_ma,
    output logic [VMV_W-1:0]         o_voltage_mv,
    output logic signed [TEMP_W-1:0] o_temperature_c,
    output logic                     o_undervoltage,
    output logic                     o_overtemperature
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEMP,
        S_PWR,
        S_LIM_GO,
        S_LIM,
        S_SET_GO,
        S_SET,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic                      r_power_mode;
    logic [SET_W-1:0]          r_req_current;
    logic [SET_W-1:0]          r_req_power;
    logic [VMV_W-1:0]          r_vmv;
    logic                      r_uv;
    logic                      r_ot;
    logic signed [TEMP_W-1:0]  r_temp;
    logic [PWR_W-1:0]          r_max_power;
    logic [PWR_W-1:0]          r_p;
    logic [LIM_W-1:0]          r_limit;
    logic [SETP_W-1:0]         r_setpoint;
    logic                      r_out_valid;
    logic [SETP_W-1:0]         r_o_setpoint;
    logic [LIM_W-1:0]          r_o_limit;
    logic [VMV_W-1:0]          r_o_vmv;
    logic signed [TEMP_W-1:0]  r_o_temp;
    logic                      r_o_uv;
    logic                      r_o_ot;

    logic [CODE_W-1:0]         n_vcode;
    logic [CODE_W-1:0]         n_tcode;
    logic [VMV_W-1:0]          n_vmv;
    logic [TPROD_W-1:0]        n_tprod;
    logic signed [MP_W-1:0]    n_temp_ext;
    logic signed [MP_W-1:0]    n_mp_raw;
    logic                      n_ot;
    logic [PWR_W-1:0]          n_max_power;
    logic [PREQ_W-1:0]         n_p_req;
    logic [PWR_W-1:0]          n_p;
    logic [PWR_W-1:0]          n_mul_src;
    logic [PROD_W-1:0]         n_prod;
    logic [LIM_W-1:0]          n_limit;
    logic                      n_take;
    t_div_req                  n_div_req;
    t_div_rsp                  w_div_rsp;

    assign n_take = i_valid && !o_stall;

    always_comb begin
        n_vcode = i_voltage_code & ADC_MASK;
        n_tcode = i_temperature_code & ADC_MASK;
        n_vmv   = VMV_W'(VMV_W'(n_vcode) * VMV_W'(MV_PER_STEP));
        n_tprod = TPROD_W'(TPROD_W'(n_tcode) * TPROD_W'(T_GAIN));

        n_temp_ext = MP_W'(r_temp);
        n_mp_raw   = P_INTERCEPT_S - P_SLOPE_S * n_temp_ext;
        n_ot       = r_temp > T_MAX_S;
        if (n_ot || n_mp_raw < 0) begin
            n_max_power = '0;
        end else if (n_mp_raw > P_CAP_S) begin
            n_max_power = PWR_W'(P_CAP);
        end else begin
            n_max_power = n_mp_raw[PWR_W-1:0];
        end

        n_p_req = PREQ_W'(PREQ_W'(r_req_power) * PREQ_W'(P_SCALE));
        n_p     = (n_p_req > {1'b0, r_max_power}) ? r_max_power : n_p_req[PWR_W-1:0];

        n_mul_src = (r_state == S_SET_GO) ? r_p : r_max_power;
        n_prod    = PROD_W'(PROD_W'(n_mul_src) * PROD_W'(MILLI));

        n_limit = (w_div_rsp.quot > QUOT_W'(I_CAP)) ? LIM_W'(I_CAP)
                                                     : w_div_rsp.quot[LIM_W-1:0];

        n_div_req.start = 1'b0;
        n_div_req.rem   = REM_W'(n_prod[PROD_W-1:QUOT_W]);
        n_div_req.low   = n_prod[QUOT_W-1:0];
        n_div_req.den   = r_vmv;
        n_div_req.steps = STEP_W'(QUOT_W);
        case (r_state)
            S_IDLE: begin
                n_div_req.start = n_take && (i_operation == OP_MEASURE);
                n_div_req.rem   = REM_W'(n_tprod[TPROD_W-1:TEMP_QW]);
                n_div_req.low   = {n_tprod[TEMP_QW-1:0], {(QUOT_W - TEMP_QW){1'b0}}};
                n_div_req.den   = REM_W'(T_DIV);
                n_div_req.steps = STEP_W'(TEMP_QW);
            end
            S_LIM_GO, S_SET_GO: begin
                n_div_req.start = 1'b1;
            end
            default: begin
                n_div_req.start = 1'b0;
            end
        endcase
    end

    elsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_power_mode  <= 1'b0;
            r_req_current <= '0;
            r_req_power   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_take) begin
                        if (i_operation == OP_MEASURE) begin
                            r_vmv   <= n_vmv;
                            r_uv    <= n_vmv < VMV_W'(V_MIN_MV);
                            r_state <= S_TEMP;
                        end else if (i_command_word[CMD_MODE_BIT]) begin
                            r_power_mode <= 1'b1;
                            r_req_power  <= i_command_word[SET_W-1:0];
                        end else begin
                            r_power_mode  <= 1'b0;
                            r_req_current <= i_command_word[SET_W-1:0];
                        end
                    end
                end
                S_TEMP: begin
                    if (w_div_rsp.done) begin
                        r_temp  <= {1'b0, w_div_rsp.quot[TEMP_QW-1:0]} - TEMP_W'(T_OFFSET);
                        r_state <= S_PWR;
                    end
                end
                S_PWR: begin
                    r_ot        <= n_ot;
                    r_max_power <= n_max_power;
                    if (r_uv) begin
                        r_limit    <= '0;
                        r_setpoint <= '0;
                        r_state    <= S_FIN;
                    end else begin
                        r_state <= S_LIM_GO;
                    end
                end
                S_LIM_GO: begin
                    r_p     <= n_p;
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    if (w_div_rsp.done) begin
                        r_limit <= n_limit;
                        if (r_power_mode) begin
                            r_state <= S_SET_GO;
                        end else begin
                            r_setpoint <= (SETP_W'(r_req_current) > SETP_W'(n_limit))
                                          ? SETP_W'(n_limit) : SETP_W'(r_req_current);
                            r_state    <= S_FIN;
                        end
                    end
                end
                S_SET_GO: begin
                    r_state <= S_SET;
                end
                S_SET: begin
                    if (w_div_rsp.done) begin
                        r_setpoint <= w_div_rsp.quot;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_o_setpoint <= r_setpoint;
                        r_o_limit    <= r_limit;
                        r_o_vmv      <= r_vmv;
                        r_o_temp     <= r_temp;
                        r_o_uv       <= r_uv;
                        r_o_ot       <= r_ot;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall               = r_state != S_IDLE;
    assign o_valid               = r_out_valid;
    assign o_current_setpoint_ma = r_o_setpoint;
    assign o_current_limit_ma    = r_o_limit;
    assign o_voltage_mv          = r_o_vmv;
    assign o_temperature_c       = r_o_temp;
    assign o_undervoltage        = r_o_uv;
    assign o_overtemperature     = r_o_ot;

    `ASSERT_IMPLIES(a_uv_zero, o_valid && o_undervoltage, o_current_setpoint_ma == '0 && o_current_limit_ma == '0, "Undervoltage word carries a non-zero current.")
    `ASSERT_IMPLIES(a_ot_zero, o_valid && o_overtemperature, o_current_setpoint_ma == '0 && o_current_limit_ma == '0, "Overtemperature word carries a non-zero current.")
    `ASSERT_IMPLIES(a_lim_cap, o_valid, o_current_limit_ma <= LIM_W'(I_CAP), "Current limit exceeds its cap.")
    `ASSERT_HOLDS(a_div_idle, !(w_div_rsp.done && (r_state == S_IDLE || r_state == S_FIN)), "Divider finished with no division pending.")

endmodule
